// ===== rtl/brbfm_pkg.sv =====
// ----------------------------------------------------------------------------
// brbfm_pkg
// Shared types and codes for the byte ring buffer with frame-start mark.
// ----------------------------------------------------------------------------
package brbfm_pkg;

  // Command codes; codes above OP_STATUS act as status
  localparam logic [3:0] OP_ENQ       = 4'd0;
  localparam logic [3:0] OP_DEQ       = 4'd1;
  localparam logic [3:0] OP_CLEAR     = 4'd2;
  localparam logic [3:0] OP_SET_MARK  = 4'd3;
  localparam logic [3:0] OP_REL_MARK  = 4'd4;
  localparam logic [3:0] OP_FIND      = 4'd5;
  localparam logic [3:0] OP_FIND_NEXT = 4'd6;
  localparam logic [3:0] OP_JUMP      = 4'd7;
  localparam logic [3:0] OP_ROLLBACK  = 4'd8;
  localparam logic [3:0] OP_STATUS    = 4'd9;

  // Input transaction
  typedef struct packed {
    logic [3:0] op;
    logic [7:0] data_in;
    logic [7:0] rollback_count;
  } cmd_t;

  // Result transaction
  typedef struct packed {
    logic [7:0] data_out;
    logic       data_valid;
    logic       found;
    logic [6:0] fill_count;
    logic       is_empty;
    logic       is_full;
    logic       lost_data;
    logic       mark_held;
  } res_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DEQ,
    ST_TGT,
    ST_SCAN
  } ctl_state_t;

  // Source of the store read address
  typedef enum logic [1:0] {
    RA_READ,
    RA_MARK,
    RA_SCAN
  } raddr_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       exec;
    logic       deq;
    logic       scan_init;
    logic       tgt_from_ram;
    logic       scan_step;
    raddr_sel_t raddr_sel;
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic empty;
    logic mark;
    logic scan_done;
  } dp_stat_t;

endpackage

// ===== rtl/byte_ring_buffer_with_frame_mark_unit.sv =====
// ----------------------------------------------------------------------------
// byte_ring_buffer_with_frame_mark_unit
// Byte ring FIFO with sticky loss flag and a frame-start mark with search.
//
// Channel   Ports                          Transfer
// input     start, busy, in_cmd            start high while busy low
// result    out_valid, out_res             one-cycle strobe, no backpressure
// config    cfg_valid, cfg_ready, cfg_data cfg_valid and cfg_ready high
//
// Enqueue, clear, mark, jump, rollback and status: result the cycle after
// acceptance, next command accepted back to back.
// Dequeue: waits in ST_DEQ for the registered read port of the byte store;
// on an empty buffer it finishes like the commands above.
// Searches scan up to DEPTH - 1 bytes, one store read per cycle, until a hit
// or the write pointer; find next first fetches the byte at the mark as
// target, and finishes like the commands above when no mark is held.
// Reset is synchronous; no clearing pass, the store holds no reset value.
// ----------------------------------------------------------------------------
module byte_ring_buffer_with_frame_mark_unit import brbfm_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  cmd_t in_cmd,
  output logic out_valid,
  output res_t out_res,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_data
);

  ctl_cmd_t ctl;
  dp_stat_t stat;

  // Register write is always taken
  assign cfg_ready = 1'b1;

  brbfm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .op    (in_cmd.op),
    .stat  (stat),
    .busy  (busy),
    .ctl   (ctl)
  );

  brbfm_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_cmd    (in_cmd),
    .cfg_wr    (cfg_valid & cfg_ready),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .stat      (stat),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule

// ===== rtl/brbfm_ram.sv =====
// ----------------------------------------------------------------------------
// brbfm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module brbfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/brbfm_ctrl.sv =====
// ----------------------------------------------------------------------------
// brbfm_ctrl
// Command sequencer: decodes accepted commands, runs dequeue reads and the
// forward byte search over the store.
// ----------------------------------------------------------------------------
module brbfm_ctrl import brbfm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [3:0] op,
  input  dp_stat_t   stat,
  output logic       busy,
  output ctl_cmd_t   ctl
);

  ctl_state_t state_r;
  ctl_state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    ctl           = '0;
    ctl.raddr_sel = RA_READ;
    busy          = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (op)
            OP_DEQ: begin
              if (!stat.empty) begin
                state_nxt = ST_DEQ;
              end else begin
                ctl.exec = 1'b1;
              end
            end
            OP_FIND: begin
              ctl.scan_init = 1'b1;
              state_nxt     = ST_SCAN;
            end
            OP_FIND_NEXT: begin
              if (stat.mark) begin
                ctl.raddr_sel = RA_MARK;
                state_nxt     = ST_TGT;
              end else begin
                ctl.exec = 1'b1;
              end
            end
            default: begin
              ctl.exec = 1'b1;
            end
          endcase
        end
      end
      // Read data for the dequeue is ready
      ST_DEQ: begin
        ctl.deq   = 1'b1;
        state_nxt = ST_IDLE;
      end
      // Capture the byte at the mark as search target
      ST_TGT: begin
        ctl.scan_init    = 1'b1;
        ctl.tgt_from_ram = 1'b1;
        state_nxt        = ST_SCAN;
      end
      // Walk the store until a hit or the write pointer
      ST_SCAN: begin
        ctl.scan_step = 1'b1;
        ctl.raddr_sel = RA_SCAN;
        if (stat.scan_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/brbfm_datapath.sv =====
// ----------------------------------------------------------------------------
// brbfm_datapath
// Pointers, flags, mark, search registers, byte store and result register.
// ----------------------------------------------------------------------------
module brbfm_datapath import brbfm_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  cmd_t     in_cmd,
  input  logic     cfg_wr,
  input  logic     cfg_data,
  input  ctl_cmd_t ctl,
  output dp_stat_t stat,
  output logic     out_valid,
  output res_t     out_res
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int HW = (CW > 8) ? CW : 8;

  // Architectural state
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [PW-1:0] mark_r, mark_nxt;
  logic          empty_r, empty_nxt;
  logic          full_r, full_nxt;
  logic          loss_r, loss_nxt;
  logic          markf_r, markf_nxt;
  logic          bwf_r;

  // Search state
  logic [PW-1:0] scan_r, scan_nxt;
  logic [PW-1:0] cmp_r, cmp_nxt;
  logic          pend_r, pend_nxt;
  logic [7:0]    target_r, target_nxt;

  // Result
  res_t          res_r;
  logic          ovalid_r;

  // Store access
  logic          we;
  logic [PW-1:0] raddr;
  logic [7:0]    rdata;

  logic [7:0]    dout;
  logic          dval;
  logic          hit;
  logic          emit;
  logic          scan_hit;
  logic          scan_end;
  logic [HW-1:0] held_cur;
  logic [HW-1:0] held_nxt;
  logic [HW-1:0] rb_cnt;

  function automatic logic [PW-1:0] nslot(input logic [PW-1:0] i);
    nslot = (i == PW'(DEPTH - 1)) ? '0 : i + PW'(1);
  endfunction

  function automatic logic [HW-1:0] held_of(input logic e, input logic [PW-1:0] w,
                                            input logic [PW-1:0] r);
    if (e) begin
      held_of = '0;
    end else if (w > r) begin
      held_of = HW'(w) - HW'(r);
    end else begin
      held_of = HW'(DEPTH) - HW'(r) + HW'(w);
    end
  endfunction

  brbfm_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (wp_r),
    .wdata (in_cmd.data_in),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Read address select
  always_comb begin
    case (ctl.raddr_sel)
      RA_MARK: raddr = mark_r;
      RA_SCAN: raddr = scan_r;
      default: raddr = rp_r;
    endcase
  end

  assign scan_hit = pend_r && (rdata == target_r);
  assign scan_end = scan_hit || (scan_r == wp_r);
  assign held_cur = held_of(empty_r, wp_r, rp_r);
  assign rb_cnt   = HW'(in_cmd.rollback_count);

  // Command execution
  always_comb begin
    wp_nxt    = wp_r;
    rp_nxt    = rp_r;
    mark_nxt  = mark_r;
    empty_nxt = empty_r;
    full_nxt  = full_r;
    loss_nxt  = loss_r;
    markf_nxt = markf_r;
    dout      = '0;
    dval      = 1'b0;
    hit       = 1'b0;
    we        = 1'b0;

    if (ctl.exec) begin
      case (in_cmd.op)
        OP_ENQ: begin
          loss_nxt = loss_r | full_r;
          if (!(bwf_r && loss_nxt)) begin
            we        = 1'b1;
            wp_nxt    = nslot(wp_r);
            empty_nxt = 1'b0;
            full_nxt  = markf_r ? (wp_nxt == mark_r) : (wp_nxt == rp_r);
          end
        end
        OP_CLEAR: begin
          wp_nxt    = '0;
          rp_nxt    = '0;
          empty_nxt = 1'b1;
          full_nxt  = 1'b0;
          loss_nxt  = 1'b0;
          markf_nxt = 1'b0;
        end
        OP_SET_MARK: begin
          if (!markf_r) begin
            markf_nxt = 1'b1;
            mark_nxt  = (rp_r == '0) ? PW'(DEPTH - 1) : rp_r - PW'(1);
          end
        end
        OP_REL_MARK: begin
          markf_nxt = 1'b0;
          if (full_r && empty_r) begin
            full_nxt = 1'b0;
          end
        end
        OP_JUMP: begin
          if (markf_r) begin
            rp_nxt    = mark_r;
            empty_nxt = (wp_r == mark_r);
            full_nxt  = !empty_nxt;
          end
        end
        OP_ROLLBACK: begin
          if (!empty_r && (rb_cnt != '0)) begin
            if (rb_cnt >= held_cur) begin
              wp_nxt    = rp_r;
              empty_nxt = 1'b1;
            end else if (HW'(wp_r) >= rb_cnt) begin
              wp_nxt = PW'(HW'(wp_r) - rb_cnt);
            end else begin
              wp_nxt = PW'(HW'(wp_r) + HW'(DEPTH) - rb_cnt);
            end
            full_nxt = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end

    // Finish a dequeue with the byte read at the read pointer
    if (ctl.deq) begin
      dout      = rdata;
      dval      = 1'b1;
      rp_nxt    = nslot(rp_r);
      full_nxt  = 1'b0;
      empty_nxt = (wp_r == rp_nxt);
    end

    // Move the mark onto a search hit
    if (ctl.scan_step && scan_hit) begin
      mark_nxt = cmp_r;
      hit      = 1'b1;
    end
  end

  // Search pointer: issue one read a cycle, compare it the cycle after
  always_comb begin
    scan_nxt   = scan_r;
    cmp_nxt    = cmp_r;
    pend_nxt   = pend_r;
    target_nxt = target_r;
    if (ctl.scan_init) begin
      scan_nxt   = markf_r ? nslot(mark_r) : rp_r;
      pend_nxt   = 1'b0;
      target_nxt = ctl.tgt_from_ram ? rdata : in_cmd.data_in;
    end else if (ctl.scan_step && !scan_end) begin
      pend_nxt = 1'b1;
      cmp_nxt  = scan_r;
      scan_nxt = nslot(scan_r);
    end
  end

  assign emit     = ctl.exec | ctl.deq | (ctl.scan_step & scan_end);
  assign held_nxt = held_of(empty_nxt, wp_nxt, rp_nxt);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r     <= '0;
      rp_r     <= '0;
      mark_r   <= '0;
      empty_r  <= 1'b1;
      full_r   <= 1'b0;
      loss_r   <= 1'b0;
      markf_r  <= 1'b0;
      bwf_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      wp_r     <= wp_nxt;
      rp_r     <= rp_nxt;
      mark_r   <= mark_nxt;
      empty_r  <= empty_nxt;
      full_r   <= full_nxt;
      loss_r   <= loss_nxt;
      markf_r  <= markf_nxt;
      ovalid_r <= emit;
      if (cfg_wr) begin
        bwf_r <= cfg_data;
      end
    end
  end

  // Search and result payload
  always_ff @(posedge clk) begin
    scan_r   <= scan_nxt;
    cmp_r    <= cmp_nxt;
    pend_r   <= pend_nxt;
    target_r <= target_nxt;
    if (emit) begin
      res_r.data_out   <= dout;
      res_r.data_valid <= dval;
      res_r.found      <= hit;
      res_r.fill_count <= held_nxt[6:0];
      res_r.is_empty   <= empty_nxt;
      res_r.is_full    <= full_nxt;
      res_r.lost_data  <= loss_nxt;
      res_r.mark_held  <= markf_nxt;
    end
  end

  assign stat.empty     = empty_r;
  assign stat.mark      = markf_r;
  assign stat.scan_done = scan_end;
  assign out_valid      = ovalid_r;
  assign out_res        = res_r;

endmodule

// ===== rtl/brbfm_checker.sv =====
// ----------------------------------------------------------------------------
// brbfm_checker
// Port-level checks on command and result timing of the ring buffer.
// ----------------------------------------------------------------------------
module brbfm_checker import brbfm_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input res_t out_res
);

  // Every accepted transaction either finishes next cycle or holds busy
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("accepted transaction neither finished nor busy");

  // A result is only shown once the unit is back to idle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // Busy only starts on an accepted transaction
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a transaction");

  // Empty buffer reports no held bytes
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.is_empty) |-> (out_res.fill_count == '0))
    else $error("empty flag with nonzero fill count");

  // A dequeue never reports a search hit
  a_deq_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.data_valid) |-> !out_res.found)
    else $error("dequeue result with found set");

endmodule

bind byte_ring_buffer_with_frame_mark_unit brbfm_checker u_chk (.*);
